[sv/okl_pkg.sv]
// ----------------------------------------------------------------------------
// okl_pkg
// Shared widths, action codes and status codes for the ordered key table.
// ----------------------------------------------------------------------------
`default_nettype none

package okl_pkg;

	localparam int KEY_W     = 32;
	localparam int ACT_W     = 2;
	localparam int ST_W      = 2;
	localparam int DEPTH_DEF = 16;

	localparam logic [ACT_W-1:0] ACT_ADD    = 2'd0;
	localparam logic [ACT_W-1:0] ACT_REMOVE = 2'd1;
	localparam logic [ACT_W-1:0] ACT_SEARCH = 2'd2;
	localparam logic [ACT_W-1:0] ACT_READ   = 2'd3;

	localparam logic [ST_W-1:0] ST_OK      = 2'd0;
	localparam logic [ST_W-1:0] ST_FULL    = 2'd1;
	localparam logic [ST_W-1:0] ST_MISSING = 2'd2;
	localparam logic [ST_W-1:0] ST_RANGE   = 2'd3;

	localparam logic [KEY_W-1:0] KEY_NONE = {KEY_W{1'b1}};

endpackage : okl_pkg

`default_nettype wire

[sv/ordered_key_list_table_unit.sv]
// ----------------------------------------------------------------------------
// ordered_key_list_table_unit
// Ordered table of keys held front to back in a single-port-write memory,
// worked on by one read/compare/write sequencer.
// ----------------------------------------------------------------------------
//  Group    Direction  Signals                       Contents
//  s_*      in         s_tvalid s_tready s_tdata     operand; s_tuser = action
//  m_*      out        m_tvalid m_tready m_tdata     status, found, key, count
//
//  An add moves every held key one place back, each read and then written through
//  the one memory port pair, before the new key goes in at the front. Remove and
//  search read every held key once. A read passes through S_RDWAIT; an add to a
//  full table or an out-of-range read goes straight to S_DONE.
//  m_tvalid rises and s_tready returns at the same edge, so the next transaction
//  can be accepted even while a result waits; the following result is then held
//  in the sequencer until the output is free.
//  Reset clears the count and control state only; the memory is not cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module ordered_key_list_table_unit
	import okl_pkg::*;
#(
	parameter int DEPTH = DEPTH_DEF,
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1,
	localparam int CW    = $clog2(DEPTH + 1),
	localparam int RES_W = ST_W + 1 + KEY_W + CW,
	localparam int OUT_W = ((RES_W + 7) / 8) * 8
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             s_tvalid,
	output logic                  s_tready,
	input  wire logic [KEY_W-1:0] s_tdata,   // [31:0] operand
	input  wire logic [ACT_W-1:0] s_tuser,   // [1:0] action
	output logic                  m_tvalid,
	input  wire logic             m_tready,
	output logic [OUT_W-1:0]      m_tdata    // status, found, key_out, entry_count, zeros
);

	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_SCAN   = 3'd1;
	localparam logic [2:0] S_SHIFT  = 3'd2;
	localparam logic [2:0] S_RDWAIT = 3'd3;
	localparam logic [2:0] S_DONE   = 3'd4;

	logic [2:0]       st_q;
	logic [CW-1:0]    cnt_q;
	logic [CW-1:0]    idx_q;
	logic             rd_pend_q;
	logic             hit_q;
	logic             m_tvalid_q;
	logic [ACT_W-1:0] act_q;
	logic [KEY_W-1:0] key_q;
	logic [AW-1:0]    rd_idx_s1;
	logic [ST_W-1:0]  res_status_q;
	logic             res_found_q;
	logic [KEY_W-1:0] res_key_q;
	logic [OUT_W-1:0] m_tdata_q;

	logic [KEY_W-1:0] key_mem [DEPTH];
	logic [KEY_W-1:0] rdata_q;

	logic             mem_we;
	logic [AW-1:0]    mem_waddr;
	logic [KEY_W-1:0] mem_wdata;
	logic [AW-1:0]    mem_raddr;

	logic             accept;
	logic             full;
	logic [KEY_W-1:0] pos_w;
	logic [KEY_W-1:0] pos_dec;
	logic             out_of_range;
	logic [CW-1:0]    idx_dec;
	logic             issue;
	logic             finish;
	logic             out_free;

	assign s_tready     = (st_q == S_IDLE);
	assign accept       = s_tvalid && s_tready;
	assign full         = (cnt_q == CW'(DEPTH));
	assign pos_w        = (s_tdata == '0) ? KEY_W'(1) : s_tdata;
	assign pos_dec      = pos_w - KEY_W'(1);
	assign out_of_range = (pos_w > KEY_W'(cnt_q));
	assign idx_dec      = idx_q - CW'(1);
	assign out_free     = !m_tvalid_q || m_tready;

	// Remove compacts during the scan: once the key has matched, every later
	// entry is written one place towards the front as it is read.
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = rd_idx_s1;
		mem_wdata = rdata_q;
		mem_raddr = idx_q[AW-1:0];
		issue     = 1'b0;
		finish    = 1'b0;
		unique case (st_q)
			S_IDLE: begin
				mem_raddr = pos_dec[AW-1:0];
			end
			S_SCAN: begin
				issue = (idx_q < cnt_q);
				if (rd_pend_q && hit_q && (act_q == ACT_REMOVE)) begin
					mem_we    = 1'b1;
					mem_waddr = rd_idx_s1 - AW'(1);
				end
				finish = !rd_pend_q && !issue;
			end
			S_SHIFT: begin
				issue     = (idx_q != '0);
				mem_raddr = idx_dec[AW-1:0];
				if (rd_pend_q) begin
					mem_we = 1'b1;
				end else if (!issue) begin
					mem_we    = 1'b1;
					mem_waddr = '0;
					mem_wdata = key_q;
					finish    = 1'b1;
				end
			end
			S_RDWAIT, S_DONE: begin
				finish = 1'b0;
			end
			default: begin
				finish = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			key_mem[mem_waddr] <= mem_wdata;
		end
		rdata_q <= key_mem[mem_raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q       <= S_IDLE;
			cnt_q      <= '0;
			idx_q      <= '0;
			rd_pend_q  <= 1'b0;
			hit_q      <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			if ((st_q == S_DONE) && out_free) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tvalid_q && m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			unique case (st_q)
				S_IDLE: begin
					if (accept) begin
						hit_q     <= 1'b0;
						rd_pend_q <= 1'b0;
						unique case (s_tuser)
							ACT_ADD: begin
								if (full) begin
									st_q <= S_DONE;
								end else begin
									idx_q <= cnt_q;
									st_q  <= S_SHIFT;
								end
							end
							ACT_REMOVE, ACT_SEARCH: begin
								idx_q <= '0;
								st_q  <= S_SCAN;
							end
							ACT_READ: begin
								st_q <= out_of_range ? S_DONE : S_RDWAIT;
							end
							default: begin
								st_q <= S_IDLE;
							end
						endcase
					end
				end
				S_SCAN: begin
					rd_pend_q <= issue;
					if (issue) begin
						idx_q <= idx_q + CW'(1);
					end
					if (rd_pend_q && !hit_q && (rdata_q == key_q)) begin
						hit_q <= 1'b1;
					end
					if (finish) begin
						st_q <= S_DONE;
						if ((act_q == ACT_REMOVE) && hit_q) begin
							cnt_q <= cnt_q - CW'(1);
						end
					end
				end
				S_SHIFT: begin
					rd_pend_q <= issue;
					if (issue) begin
						idx_q <= idx_dec;
					end
					if (finish) begin
						cnt_q <= cnt_q + CW'(1);
						st_q  <= S_DONE;
					end
				end
				S_RDWAIT: begin
					st_q <= S_DONE;
				end
				S_DONE: begin
					if (out_free) begin
						st_q <= S_IDLE;
					end
				end
				default: begin
					st_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (st_q)
			S_IDLE: begin
				if (accept) begin
					act_q       <= s_tuser;
					key_q       <= s_tdata;
					res_found_q <= 1'b0;
					if ((s_tuser == ACT_ADD) && full) begin
						res_status_q <= ST_FULL;
					end else if ((s_tuser == ACT_READ) && out_of_range) begin
						res_status_q <= ST_RANGE;
					end else begin
						res_status_q <= ST_OK;
					end
					res_key_q <= ((s_tuser == ACT_READ) && out_of_range) ? KEY_NONE : '0;
				end
			end
			S_SCAN: begin
				if (issue) begin
					rd_idx_s1 <= idx_q[AW-1:0];
				end
				if (finish) begin
					res_found_q  <= hit_q;
					res_status_q <= hit_q ? ST_OK : ST_MISSING;
				end
			end
			S_SHIFT: begin
				if (issue) begin
					rd_idx_s1 <= idx_q[AW-1:0];
				end
			end
			S_RDWAIT: begin
				res_key_q <= rdata_q;
			end
			S_DONE: begin
				if (out_free) begin
					m_tdata_q <= OUT_W'({cnt_q, res_key_q, res_found_q, res_status_q});
				end
			end
			default: begin
				res_found_q <= res_found_q;
			end
		endcase
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

endmodule : ordered_key_list_table_unit

`default_nettype wire

[sv/okl_checker.sv]
// ----------------------------------------------------------------------------
// okl_checker
// Port-level checks on the ordered key table, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module okl_checker
	import okl_pkg::*;
#(
	parameter int DEPTH = DEPTH_DEF,
	localparam int CW    = $clog2(DEPTH + 1),
	localparam int RES_W = ST_W + 1 + KEY_W + CW,
	localparam int OUT_W = ((RES_W + 7) / 8) * 8
) (
	input wire logic             clk,
	input wire logic             arst_n,
	input wire logic             s_tvalid,
	input wire logic             s_tready,
	input wire logic             m_tvalid,
	input wire logic             m_tready,
	input wire logic [OUT_W-1:0] m_tdata
);

	logic [ST_W-1:0]  o_status;
	logic             o_found;
	logic [CW-1:0]    o_count;

	assign o_status = m_tdata[ST_W-1:0];
	assign o_found  = m_tdata[ST_W];
	assign o_count  = m_tdata[RES_W-1:ST_W+KEY_W+1];

	// An accepted transaction always takes the sequencer out of idle, dropping s_tready.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input accepted on two consecutive cycles");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (o_count <= CW'(DEPTH)))
		else $error("entry count exceeds table depth");

	a_full_count: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (o_status == ST_FULL) |-> (o_count == CW'(DEPTH)))
		else $error("table full reported below depth");

	a_found_ok: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && o_found |-> (o_status == ST_OK))
		else $error("match reported with a failing status");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("stalled result changed or was dropped");

endmodule : okl_checker

bind ordered_key_list_table_unit okl_checker #(.DEPTH(DEPTH)) u_okl_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

`default_nettype wire
